// ===== hdl/spdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_pkg
// Shared types and constants for the strict-priority dual queue.
// ----------------------------------------------------------------------------
package spdf_pkg;

	localparam int DEPTH   = 16;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 48;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic exec;      // update queues, register result fields
		logic load_word; // load read data into the result word
	} spdf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic read_needed; // captured item is a dequeue that finds data
	} spdf_stat_t;

endpackage

// ===== hdl/strict_priority_dual_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_dual_fifo
// Urgent and normal queues with a shared capacity of DEPTH entries; dequeue serves urgent first.
// ----------------------------------------------------------------------------
// out_valid is registered: it rises after the execute state for an enqueue, a
//   rejected enqueue or an empty dequeue, and after the read state for a dequeue
//   that returns data (registered RAM read). The sequencer holds one item at a
//   time and takes no new item until it is idle and the result register is free.
// Reset: arst_n clears pointers, counts, state and the output valid; storage
//   contents are not cleared.
module strict_priority_dual_fifo import spdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic              is_urgent,
	input  logic [WORD_W-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] out_value,
	output logic              from_urgent,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  occupancy
);

	spdf_cmd_t  cmd;
	spdf_stat_t stat;

	spdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	spdf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.is_urgent   (is_urgent),
		.value       (value),
		.out_value   (out_value),
		.from_urgent (from_urgent),
		.status      (status),
		.occupancy   (occupancy)
	);

endmodule

// ===== hdl/spdf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_datapath
// Queue storage, pointers, counts and the result register.
// ----------------------------------------------------------------------------
module spdf_datapath import spdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  spdf_cmd_t         cmd,
	output spdf_stat_t        stat,
	input  logic              op,
	input  logic              is_urgent,
	input  logic [WORD_W-1:0] value,
	output logic [WORD_W-1:0] out_value,
	output logic              from_urgent,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  occupancy
);

	logic [WORD_W-1:0] urg_mem [DEPTH];
	logic [WORD_W-1:0] nrm_mem [DEPTH];

	op_t               op_q;
	logic              urg_q;
	logic [WORD_W-1:0] value_q;

	logic [PTR_W-1:0]  urg_wp_q, urg_rp_q, nrm_wp_q, nrm_rp_q;
	logic [CNT_W-1:0]  urg_cnt_q, nrm_cnt_q;

	logic [WORD_W-1:0] urg_rd_q, nrm_rd_q;
	logic              src_urg_q;

	logic [WORD_W-1:0] res_value_q;
	logic              res_urg_q;
	status_t           res_status_q;
	logic [CNT_W-1:0]  res_occ_q;

	logic [CNT_W-1:0]  total;
	logic              full, urg_any, nrm_any;
	logic              do_enq, do_deq_urg, do_deq_nrm;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign total      = urg_cnt_q + nrm_cnt_q;
	assign full       = (total == CNT_W'(DEPTH));
	assign urg_any    = (urg_cnt_q != '0);
	assign nrm_any    = (nrm_cnt_q != '0);
	assign do_enq     = (op_q == OP_ENQ) && !full;
	assign do_deq_urg = (op_q == OP_DEQ) && urg_any;
	assign do_deq_nrm = (op_q == OP_DEQ) && !urg_any && nrm_any;

	assign stat.read_needed = (op_q == OP_DEQ) && (urg_any || nrm_any);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(op);
			urg_q   <= is_urgent;
			value_q <= value;
		end
	end

	// storage: one write port and one registered read port per queue
	always_ff @(posedge clk) begin
		if (cmd.exec && do_enq && urg_q) begin
			urg_mem[urg_wp_q] <= value_q;
		end
		if (cmd.exec && do_enq && !urg_q) begin
			nrm_mem[nrm_wp_q] <= value_q;
		end
		if (cmd.exec) begin
			urg_rd_q  <= urg_mem[urg_rp_q];
			nrm_rd_q  <= nrm_mem[nrm_rp_q];
			src_urg_q <= urg_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urg_wp_q  <= '0;
			urg_rp_q  <= '0;
			nrm_wp_q  <= '0;
			nrm_rp_q  <= '0;
			urg_cnt_q <= '0;
			nrm_cnt_q <= '0;
		end else if (cmd.exec) begin
			if (do_enq && urg_q) begin
				urg_wp_q  <= wrap_next(urg_wp_q);
				urg_cnt_q <= urg_cnt_q + CNT_W'(1);
			end
			if (do_enq && !urg_q) begin
				nrm_wp_q  <= wrap_next(nrm_wp_q);
				nrm_cnt_q <= nrm_cnt_q + CNT_W'(1);
			end
			if (do_deq_urg) begin
				urg_rp_q  <= wrap_next(urg_rp_q);
				urg_cnt_q <= urg_cnt_q - CNT_W'(1);
			end
			if (do_deq_nrm) begin
				nrm_rp_q  <= wrap_next(nrm_rp_q);
				nrm_cnt_q <= nrm_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_value_q <= '0;
			res_urg_q   <= do_deq_urg;
			priority if (op_q == OP_ENQ && full) begin
				res_status_q <= ST_FULL;
				res_occ_q    <= total;
			end else if (op_q == OP_ENQ) begin
				res_status_q <= ST_OK;
				res_occ_q    <= total + CNT_W'(1);
			end else if (urg_any || nrm_any) begin
				res_status_q <= ST_OK;
				res_occ_q    <= total - CNT_W'(1);
			end else begin
				res_status_q <= ST_EMPTY;
				res_occ_q    <= total;
			end
		end
		if (cmd.load_word) begin
			res_value_q <= src_urg_q ? urg_rd_q : nrm_rd_q;
		end
	end

	assign out_value   = res_value_q;
	assign from_urgent = res_urg_q;
	assign status      = res_status_q;
	assign occupancy   = res_occ_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total <= CNT_W'(DEPTH))
		else $error("queue total exceeds capacity");

	a_rejected_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_ENQ && full) |=> $stable(total))
		else $error("rejected enqueue changed the queue counts");

	a_urgent_first: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_DEQ && urg_any) |=> $stable(nrm_cnt_q))
		else $error("normal queue served while urgent queue held data");

endmodule

// ===== hdl/spdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_ctrl
// Sequencer for one item at a time and the output valid register.
// ----------------------------------------------------------------------------
module spdf_ctrl import spdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output spdf_cmd_t  cmd,
	input  spdf_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free, accept, load_out;

	// result register frees up at the same edge it is taken
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;

	assign cmd.capture   = accept;
	assign cmd.exec      = (state_q == S_EXEC);
	assign cmd.load_word = (state_q == S_READ);

	assign load_out = ((state_q == S_EXEC) && !stat.read_needed) || (state_q == S_READ);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_EXEC;
			S_EXEC: state_d = stat.read_needed ? S_READ : S_IDLE;
			S_READ: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted item did not enter execute");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_READ))
		else $error("result valid without a finished item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && out_stall))
		else $error("pending result overwritten");

endmodule
